[hw/rtl/bole_pkg.sv]
// Package for the bounded ordered list engine.
// Request/response payload types, opcode and status codes. No dependencies.
package bole_pkg;

   typedef enum logic [2:0] {
      OP_INSERT  = 3'd0,
      OP_APPEND  = 3'd1,
      OP_DELETE  = 3'd2,
      OP_DEL_END = 3'd3,
      OP_SEARCH  = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] item_value;
      logic [6:0]         position;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [6:0] list_length;
   } rsp_type;

endpackage

[hw/rtl/bounded_ordered_list_engine.sv]
// Top level of the bounded ordered list engine.
// Uses bole_pkg; holds the element memory and the shift/search sequencer.

// Ordered list of up to CAPACITY signed 32-bit values in one synchronous
// memory (one write, one read port, registered read data). One request is
// worked at a time. Append, delete-last, insert or delete at the end
// position, search of an empty list and every refused request answer in
// the cycle after the accept. Insert and delete at position move the tail
// one entry per cycle, and search reads one entry per cycle. The response
// sits in an output register and the next request is taken in the cycle
// after it has been delivered.
module bounded_ordered_list_engine
   import bole_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_INS    = 5'b00010,
      S_DEL    = 5'b00100,
      S_SRCH   = 5'b01000,
      S_RESP   = 5'b10000
   } state_type;

   logic signed [31:0] mem [CAPACITY];

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;       // first address read by the current operation
   logic [CW-1:0]      pos_ff, pos_in;
   logic signed [31:0] val_ff, val_in;
   logic [CW-1:0]      pidx_ff, pidx_in;     // address of pending read data
   logic               found_ff, found_in;
   logic [1:0]         st_ff, st_in;
   logic               ins_tail_ff, ins_tail_in;

   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic signed [31:0] rd_data_ff;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;

   logic [CW-1:0] req_pos;
   logic          pos_fits;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // position fits the count width only if its upper bits are zero
   always_comb begin
      if (CW >= 7) begin
         req_pos  = CW'(req_data.position);
         pos_fits = 1'b1;
      end else begin
         req_pos  = req_data.position[CW-1:0];
         pos_fits = ((req_data.position >> CW) == 7'd0);
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   always_comb begin
      rsp_data.status      = st_ff;
      rsp_data.found       = found_ff;
      rsp_data.list_length = 7'(count_ff);
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      val_in      = val_ff;
      pidx_in     = pidx_ff;
      found_in    = found_ff;
      st_in       = st_ff;
      ins_tail_in = 1'b0;
      rd_en       = 1'b0;
      rd_addr     = idx_ff[AW-1:0];
      wr_en       = 1'b0;
      wr_addr     = idx_ff[AW-1:0];
      wr_data     = val_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               found_in = 1'b0;
               st_in    = ST_DONE;
               val_in   = req_data.item_value;
               pos_in   = req_pos;
               state_in = S_RESP;
               case (req_data.opcode)
                  OP_INSERT: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        st_in = ST_FULL;
                     end else if (!pos_fits || req_pos > count_ff) begin
                        st_in = ST_RANGE;
                     end else if (req_pos == count_ff) begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req_data.item_value;
                        count_in = count_ff + 1'b1;
                     end else begin
                        // read the last entry first; shift up walking down
                        rd_en    = 1'b1;
                        rd_addr  = AW'(count_ff - 1'b1);
                        pidx_in  = count_ff - 1'b1;
                        idx_in   = count_ff - 1'b1;
                        state_in = S_INS;
                     end
                  end
                  OP_APPEND: begin
                     if (count_ff >= CW'(CAPACITY)) begin
                        st_in = ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req_data.item_value;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        st_in = ST_EMPTY;
                     end else if (!pos_fits || req_pos >= count_ff) begin
                        st_in = ST_RANGE;
                     end else if (req_pos == count_ff - 1'b1) begin
                        count_in = count_ff - 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_pos + 1'b1);
                        pidx_in  = req_pos + 1'b1;
                        idx_in   = req_pos + 1'b1;
                        state_in = S_DEL;
                     end
                  end
                  OP_DEL_END: begin
                     if (count_ff == '0) begin
                        st_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        pidx_in  = '0;
                        idx_in   = '0;
                        state_in = S_SRCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_INS: begin
            // entry pidx moves to pidx+1; read next lower entry meanwhile
            wr_en   = 1'b1;
            wr_addr = AW'(pidx_ff + 1'b1);
            wr_data = rd_data_ff;
            if (pidx_ff == pos_ff) begin
               ins_tail_in = 1'b1;
               state_in    = S_RESP;
            end else begin
               rd_en   = 1'b1;
               rd_addr = AW'(pidx_ff - 1'b1);
               pidx_in = pidx_ff - 1'b1;
            end
         end
         S_DEL: begin
            wr_en   = 1'b1;
            wr_addr = AW'(pidx_ff - 1'b1);
            wr_data = rd_data_ff;
            if (pidx_ff + 1'b1 == count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_RESP;
            end else begin
               rd_en   = 1'b1;
               rd_addr = AW'(pidx_ff + 1'b1);
               pidx_in = pidx_ff + 1'b1;
            end
         end
         S_SRCH: begin
            if (rd_data_ff == val_ff) begin
               found_in = 1'b1;
               state_in = S_RESP;
            end else if (pidx_ff + 1'b1 == count_ff) begin
               state_in = S_RESP;
            end else begin
               rd_en   = 1'b1;
               rd_addr = AW'(pidx_ff + 1'b1);
               pidx_in = pidx_ff + 1'b1;
            end
         end
         S_RESP: begin
            // insert finishes by writing the new value at its position
            if (ins_tail_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff[AW-1:0];
               wr_data = val_ff;
            end
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (state_ff == S_INS && pidx_ff == pos_ff) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         ins_tail_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         ins_tail_ff <= ins_tail_in;
      end
      idx_ff   <= idx_in;
      pos_ff   <= pos_in;
      val_ff   <= val_in;
      pidx_ff  <= pidx_in;
      found_ff <= found_in;
      st_ff    <= st_in;
   end

endmodule

[hw/rtl/bole_checker.sv]
// Port-level checker for the bounded ordered list engine, with its bind.
// Uses bole_pkg.
module bole_checker
   import bole_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_found_search: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.status == ST_DONE)
      else $error("found set with failing status");

   a_append_grow: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.opcode == OP_APPEND
      |=> rsp_valid && (rsp_data.status == ST_FULL || rsp_data.list_length != 7'd0))
      else $error("append gave an empty list");

endmodule

bind bounded_ordered_list_engine bole_checker u_bole_checker (.*);
